// ===== sv/bst_pkg.sv =====
// Shared types and constants for the binary search tree insert engine.
// No dependencies; imported by bst_insert_engine.
package bst_pkg;

   localparam int MAX_NODES_DEF = 15;
   localparam int KEY_W         = 64;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 4;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_WRITE,
      S_LINK,
      S_DONE
   } bst_state_type;

endpackage

// ===== sv/bst_insert_engine.sv =====
// The key is accepted in S_IDLE; unless the tree is empty, S_CMP then walks it
// one level a cycle. An insert writes the new node in S_WRITE and, below the root,
// links it to its parent in S_LINK; a duplicate or a full tree goes straight to
// S_DONE, which loads the result register. One transaction at a time.
// Reset (synchronous, active high) empties the tree; node memory is not cleared.
// Depends on bst_pkg.
module bst_insert_engine #(
   parameter int MAX_NODES = bst_pkg::MAX_NODES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bst_pkg::KEY_W-1:0]    req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bst_pkg::STATUS_W-1:0] rsp_status,
   output logic [bst_pkg::COUNT_W-1:0]  rsp_node_count
);
   import bst_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES + 1);
   localparam int DEPTH = MAX_NODES + 1;
   localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);
   localparam logic [IDX_W-1:0] NIL  = '0;

   bst_state_type state_ff, state_in;

   logic [KEY_W-1:0]    key_ff, key_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    parent_ff, parent_in;
   logic                go_left_ff, go_left_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    nodes_used_ff, nodes_used_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // node memory
   logic [KEY_W-1:0] key_mem   [0:DEPTH-1];
   logic [IDX_W-1:0] left_mem  [0:DEPTH-1];
   logic [IDX_W-1:0] right_mem [0:DEPTH-1];
   logic [KEY_W-1:0] rd_key_ff;
   logic [IDX_W-1:0] rd_left_ff;
   logic [IDX_W-1:0] rd_right_ff;

   logic             key_we, left_we, right_we;
   logic [IDX_W-1:0] key_wa, left_wa, right_wa;
   logic [IDX_W-1:0] left_wd, right_wd;

   logic                   key_eq, go_left, full, rsp_free;
   logic [IDX_W-1:0]       child, fresh;
   logic [IDX_W+COUNT_W-1:0] count_ext;

   assign key_eq    = rd_key_ff == key_ff;
   assign go_left   = rd_key_ff > key_ff;
   assign child     = go_left ? rd_left_ff : rd_right_ff;
   assign full      = nodes_used_ff >= IDX_W'(MAX_NODES);
   assign fresh     = nodes_used_ff + ROOT;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign count_ext = {{COUNT_W{1'b0}}, nodes_used_ff};

   assign req_stall      = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node_count = rsp_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (nodes_used_ff == NIL) ? S_WRITE : S_CMP;
            end
         end
         S_CMP: begin
            if (key_eq) begin
               state_in = S_DONE;
            end else if (child == NIL) begin
               state_in = full ? S_DONE : S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = (parent_ff == NIL) ? S_DONE : S_LINK;
         end
         S_LINK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      key_in        = key_ff;
      cur_in        = cur_ff;
      parent_in     = parent_ff;
      go_left_in    = go_left_ff;
      status_in     = status_ff;
      nodes_used_in = nodes_used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      key_we        = 1'b0;
      left_we       = 1'b0;
      right_we      = 1'b0;
      key_wa        = fresh;
      left_wa       = fresh;
      right_wa      = fresh;
      left_wd       = NIL;
      right_wd      = NIL;
      case (state_ff)
         S_IDLE: begin
            cur_in    = ROOT;
            parent_in = NIL;
            if (req_valid) begin
               key_in = req_key;
            end
         end
         S_CMP: begin
            parent_in  = cur_ff;
            go_left_in = go_left;
            cur_in     = child;
            status_in  = key_eq ? ST_DUPLICATE : ST_FULL;
         end
         S_WRITE: begin
            key_we        = 1'b1;
            left_we       = 1'b1;
            right_we      = 1'b1;
            nodes_used_in = fresh;
            status_in     = ST_INSERTED;
         end
         S_LINK: begin
            // nodes_used_ff already holds the new node index
            if (go_left_ff) begin
               left_we = 1'b1;
               left_wa = parent_ff;
               left_wd = nodes_used_ff;
            end else begin
               right_we = 1'b1;
               right_wa = parent_ff;
               right_wd = nodes_used_ff;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ext[COUNT_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nodes_used_ff <= NIL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      parent_ff     <= parent_in;
      go_left_ff    <= go_left_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_ff;
      end
      rd_key_ff <= key_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_wa] <= left_wd;
      end
      rd_left_ff <= left_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[right_wa] <= right_wd;
      end
      rd_right_ff <= right_mem[cur_in];
   end

endmodule
